>>> src/asbb_pkg.sv
// ----------------------------------------------------------------------------
// asbb_pkg
// shared types and constants of the annular sector bounding box block
// ----------------------------------------------------------------------------
package asbb_pkg;

    localparam logic [30:0] COEF_A1 = 31'd1686629713;
    localparam logic [29:0] COEF_A3 = 30'd688904866;
    localparam logic [26:0] COEF_A5 = 27'd76016977;

    localparam int SIN_STEPS = 4;

    // sector cases: start sign quadrant, then end sign quadrant (x sign, y sign)
    localparam logic [3:0] SEC_PP_PP = 4'd0;
    localparam logic [3:0] SEC_PP_NP = 4'd1;
    localparam logic [3:0] SEC_PP_PN = 4'd2;
    localparam logic [3:0] SEC_PP_NN = 4'd3;
    localparam logic [3:0] SEC_NP_PP = 4'd4;
    localparam logic [3:0] SEC_NP_NP = 4'd5;
    localparam logic [3:0] SEC_NP_PN = 4'd6;
    localparam logic [3:0] SEC_NP_NN = 4'd7;
    localparam logic [3:0] SEC_PN_PP = 4'd8;
    localparam logic [3:0] SEC_PN_NP = 4'd9;
    localparam logic [3:0] SEC_PN_PN = 4'd10;
    localparam logic [3:0] SEC_PN_NN = 4'd11;
    localparam logic [3:0] SEC_NN_PP = 4'd12;
    localparam logic [3:0] SEC_NN_NP = 4'd13;
    localparam logic [3:0] SEC_NN_PN = 4'd14;
    localparam logic [3:0] SEC_NN_NN = 4'd15;

    typedef struct packed {
        logic [30:0] z;
        logic [30:0] z2;
        logic [31:0] acc;
    } t_sin_word;

endpackage

>>> src/annular_sector_bounding_box_core.sv
// ----------------------------------------------------------------------------
// annular_sector_bounding_box_core
// axis-aligned bounding box of an annular sector, fully pipelined
//
//  channel | direction | handshake          | word
//  in      | sink      | i_valid / o_stall  | radii, start angle, span
//  out     | source    | o_valid / i_stall  | xmin, ymin, xmax, ymax
//
// one word per cycle sustained while the output is not stalled; from accept to
// o_valid a word passes the input register, the four-cell sine chain, then
// the trig, scale and output stages
// synchronous active-low reset clears all stage valid flags
// a held output stalls the whole pipe; o_stall is high only while it is held
// ----------------------------------------------------------------------------
module annular_sector_bounding_box_core
    import asbb_pkg::*;
#(
    parameter int RADIUS_BITS = 24,
    parameter int ANGLE_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [RADIUS_BITS-1:0]       i_inner_radius,
    input  logic [RADIUS_BITS-1:0]       i_outer_radius,
    input  logic [ANGLE_BITS-1:0]        i_start_angle,
    input  logic [ANGLE_BITS:0]          i_span_angle,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [RADIUS_BITS:0]  o_box_xmin,
    output logic signed [RADIUS_BITS:0]  o_box_ymin,
    output logic signed [RADIUS_BITS:0]  o_box_xmax,
    output logic signed [RADIUS_BITS:0]  o_box_ymax
);

    localparam int                  DEPTH = SIN_STEPS + 3;
    localparam logic [ANGLE_BITS-1:0] QTR  = ANGLE_BITS'(1) << (ANGLE_BITS-2);
    localparam logic [ANGLE_BITS-1:0] HALF = ANGLE_BITS'(1) << (ANGLE_BITS-1);
    localparam logic [ANGLE_BITS-1:0] TQTR = QTR + HALF;

    typedef logic signed [RADIUS_BITS:0] t_len;

    typedef struct packed {
        logic [RADIUS_BITS-1:0] rmin;
        logic [RADIUS_BITS-1:0] rmax;
        logic [1:0]             s_quad;
        logic [1:0]             e_quad;
        logic                   full;
        logic                   back;
        logic [3:0]             kase;
    } t_side;

    logic                    adv;
    logic [DEPTH-1:0]        r_v;
    t_side                   r_side [DEPTH];
    t_side                   n_side;
    logic [ANGLE_BITS-1:0]   r_s;
    logic [ANGLE_BITS-1:0]   r_e;
    logic [ANGLE_BITS-1:0]   n_e;
    logic [ANGLE_BITS-2:0]   lane_x [4];
    t_sin_word               w [4][SIN_STEPS+1];
    logic signed [16:0]      r_trig [4];
    logic signed [16:0]      n_trig [4];
    logic [15:0]             pm [4];
    t_len                    len_min [4];
    t_len                    len_max [4];
    logic                    r_out_valid;
    t_len                    r_xmin, r_ymin, r_xmax, r_ymax;
    t_len                    n_xmin, n_ymin, n_xmax, n_ymax;

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = !adv;

    // input stage
    always_comb begin
        n_e         = i_start_angle + i_span_angle[ANGLE_BITS-1:0];
        n_side.rmin = i_inner_radius;
        n_side.rmax = i_outer_radius;
        n_side.s_quad = i_start_angle[ANGLE_BITS-1:ANGLE_BITS-2];
        n_side.e_quad = n_e[ANGLE_BITS-1:ANGLE_BITS-2];
        n_side.full = i_span_angle[ANGLE_BITS];
        n_side.back = n_e < i_start_angle;
        n_side.kase = {i_start_angle > HALF,
                       (i_start_angle > QTR) && (i_start_angle < TQTR),
                       n_e > HALF,
                       (n_e > QTR) && (n_e < TQTR)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= n_side;
            r_s       <= i_start_angle;
            r_e       <= n_e;
            for (int k = 1; k < DEPTH; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // sine lanes: sin(off) and sin(quarter-off) of start and end
    always_comb begin
        lane_x[0] = {1'b0, r_s[ANGLE_BITS-3:0]};
        lane_x[1] = QTR[ANGLE_BITS-2:0] - {1'b0, r_s[ANGLE_BITS-3:0]};
        lane_x[2] = {1'b0, r_e[ANGLE_BITS-3:0]};
        lane_x[3] = QTR[ANGLE_BITS-2:0] - {1'b0, r_e[ANGLE_BITS-3:0]};
    end

    genvar l, c;
    generate
        for (l = 0; l < 4; l++) begin : g_lane
            assign w[l][0].z   = 31'(lane_x[l]) << (32-ANGLE_BITS);
            assign w[l][0].z2  = '0;
            assign w[l][0].acc = '0;
            for (c = 0; c < SIN_STEPS; c++) begin : g_cell
                asbb_sin_cell #(.STEP(c)) u_cell (
                    .i_clk  (i_clk),
                    .i_en   (adv),
                    .i_word (w[l][c]),
                    .o_word (w[l][c+1])
                );
            end
        end
    endgenerate

    // rounding, clamp and quadrant folding
    always_comb begin
        logic [32:0] sum;
        logic [17:0] r;
        for (int k = 0; k < 4; k++) begin
            sum   = {1'b0, w[k][SIN_STEPS].acc} + 33'd16384;
            r     = sum[32:15];
            pm[k] = (r > 18'd32768) ? 16'd32768 : r[15:0];
        end
        unique case (r_side[SIN_STEPS].s_quad)
            2'd0: begin n_trig[0] =  $signed({1'b0, pm[0]}); n_trig[1] =  $signed({1'b0, pm[1]}); end
            2'd1: begin n_trig[0] =  $signed({1'b0, pm[1]}); n_trig[1] = -$signed({1'b0, pm[0]}); end
            2'd2: begin n_trig[0] = -$signed({1'b0, pm[0]}); n_trig[1] = -$signed({1'b0, pm[1]}); end
            default: begin n_trig[0] = -$signed({1'b0, pm[1]}); n_trig[1] = $signed({1'b0, pm[0]}); end
        endcase
        unique case (r_side[SIN_STEPS].e_quad)
            2'd0: begin n_trig[2] =  $signed({1'b0, pm[2]}); n_trig[3] =  $signed({1'b0, pm[3]}); end
            2'd1: begin n_trig[2] =  $signed({1'b0, pm[3]}); n_trig[3] = -$signed({1'b0, pm[2]}); end
            2'd2: begin n_trig[2] = -$signed({1'b0, pm[2]}); n_trig[3] = -$signed({1'b0, pm[3]}); end
            default: begin n_trig[2] = -$signed({1'b0, pm[3]}); n_trig[3] = $signed({1'b0, pm[2]}); end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_trig <= n_trig;
        end
    end

    // products: index 0 ss, 1 cs, 2 se, 3 ce
    genvar j;
    generate
        for (j = 0; j < 4; j++) begin : g_scale
            asbb_scale #(.RADIUS_BITS(RADIUS_BITS)) u_min (
                .i_clk  (i_clk),
                .i_en   (adv),
                .i_rad  (r_side[SIN_STEPS+1].rmin),
                .i_trig (r_trig[j]),
                .o_len  (len_min[j])
            );
            asbb_scale #(.RADIUS_BITS(RADIUS_BITS)) u_max (
                .i_clk  (i_clk),
                .i_en   (adv),
                .i_rad  (r_side[SIN_STEPS+1].rmax),
                .i_trig (r_trig[j]),
                .o_len  (len_max[j])
            );
        end
    endgenerate

    // case selection
    always_comb begin
        t_len  big;
        t_side sd;
        sd     = r_side[DEPTH-1];
        big    = $signed({1'b0, sd.rmax});
        n_xmin = -big;
        n_ymin = -big;
        n_xmax = big;
        n_ymax = big;
        if (!sd.full) begin
            unique case (sd.kase)
                SEC_PP_PP: begin
                    if (!sd.back) begin
                        n_xmin = len_min[3]; n_ymin = len_min[0];
                        n_xmax = len_max[1]; n_ymax = len_max[2];
                    end
                end
                SEC_PP_NP: begin
                    n_xmin = len_max[3];
                    n_ymin = (len_min[0] < len_min[2]) ? len_min[0] : len_min[2];
                    n_xmax = len_max[1];
                end
                SEC_PP_PN: begin
                    n_xmax = (len_max[1] > len_max[3]) ? len_max[1] : len_max[3];
                end
                SEC_PP_NN: begin
                    n_ymin = len_max[2]; n_xmax = len_max[1];
                end
                SEC_NP_PP: begin
                    n_ymax = (len_max[0] > len_max[2]) ? len_max[0] : len_max[2];
                end
                SEC_NP_NP: begin
                    if (!sd.back) begin
                        n_xmin = len_max[3]; n_ymin = len_min[2];
                        n_xmax = len_min[1]; n_ymax = len_max[0];
                    end
                end
                SEC_NP_PN: begin
                    n_xmax = len_max[3]; n_ymax = len_max[0];
                end
                SEC_NP_NN: begin
                    n_ymin = len_max[2];
                    n_xmax = (len_min[1] > len_min[3]) ? len_min[1] : len_min[3];
                    n_ymax = len_max[0];
                end
                SEC_PN_PP: begin
                    n_xmin = (len_min[1] < len_min[3]) ? len_min[1] : len_min[3];
                    n_ymin = len_max[0]; n_ymax = len_max[2];
                end
                SEC_PN_NP: begin
                    n_xmin = len_max[3]; n_ymin = len_max[0];
                end
                SEC_PN_PN: begin
                    if (!sd.back) begin
                        n_xmin = len_min[1]; n_ymin = len_max[0];
                        n_xmax = len_max[3]; n_ymax = len_min[2];
                    end
                end
                SEC_PN_NN: begin
                    n_ymin = (len_max[0] < len_max[2]) ? len_max[0] : len_max[2];
                end
                SEC_NN_PP: begin
                    n_xmin = len_max[1]; n_ymax = len_max[2];
                end
                SEC_NN_NP: begin
                    n_xmin = (len_max[1] < len_max[3]) ? len_max[1] : len_max[3];
                end
                SEC_NN_PN: begin
                    n_xmin = len_max[1]; n_xmax = len_max[3];
                    n_ymax = (len_min[0] > len_min[2]) ? len_min[0] : len_min[2];
                end
                SEC_NN_NN: begin
                    if (!sd.back) begin
                        n_xmin = len_max[1]; n_ymin = len_max[2];
                        n_xmax = len_min[3]; n_ymax = len_min[0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_v[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_xmin <= n_xmin;
            r_ymin <= n_ymin;
            r_xmax <= n_xmax;
            r_ymax <= n_ymax;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_box_xmin = r_xmin;
    assign o_box_ymin = r_ymin;
    assign o_box_xmax = r_xmax;
    assign o_box_ymax = r_ymax;

`ifndef SYNTH
    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output free");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && (r_v == '0)))
        else $error("pipeline not empty after reset");

    a_last_stage_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[DEPTH-1] && !o_stall) |=> o_valid)
        else $error("finished word lost before output");
`endif

endmodule

>>> src/asbb_sin_cell.sv
// ----------------------------------------------------------------------------
// asbb_sin_cell
// one registered step of the quarter-wave sine polynomial
// ----------------------------------------------------------------------------
module asbb_sin_cell
    import asbb_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_sin_word i_word,
    output t_sin_word o_word
);

    t_sin_word r_word;
    t_sin_word n_word;

    generate
        if (STEP == 0) begin : g_sq
            logic [61:0] prod;
            always_comb begin
                prod          = i_word.z * i_word.z;
                n_word        = i_word;
                n_word.z2     = prod[60:30];
            end
        end else if (STEP == 1) begin : g_t
            logic [57:0] prod;
            always_comb begin
                prod          = COEF_A5 * i_word.z2;
                n_word        = i_word;
                n_word.acc    = 32'(COEF_A3) - 32'(prod[57:30]);
            end
        end else if (STEP == 2) begin : g_u
            logic [60:0] prod;
            always_comb begin
                prod          = i_word.acc[29:0] * i_word.z2;
                n_word        = i_word;
                n_word.acc    = 32'(COEF_A1) - 32'(prod[60:30]);
            end
        end else begin : g_s
            logic [61:0] prod;
            always_comb begin
                prod          = i_word.acc[30:0] * i_word.z;
                n_word        = i_word;
                n_word.acc    = prod[61:30];
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

>>> src/asbb_scale.sv
// ----------------------------------------------------------------------------
// asbb_scale
// radius times q1.15 trig value, rounded half away from zero, registered
// ----------------------------------------------------------------------------
module asbb_scale
    import asbb_pkg::*;
#(
    parameter int RADIUS_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [RADIUS_BITS-1:0]        i_rad,
    input  logic signed [16:0]            i_trig,
    output logic signed [RADIUS_BITS:0]   o_len
);

    logic        [16:0]              neg_trig;
    logic        [15:0]              mag;
    logic        [RADIUS_BITS+15:0]  prod;
    logic        [RADIUS_BITS:0]     rnd;
    logic signed [RADIUS_BITS:0]     n_len;
    logic signed [RADIUS_BITS:0]     r_len;

    always_comb begin
        neg_trig = 17'(-i_trig);
        mag      = i_trig[16] ? neg_trig[15:0] : i_trig[15:0];
        prod     = i_rad * mag;
        prod     = prod + (RADIUS_BITS+16)'(16384);
        rnd      = prod[RADIUS_BITS+15:15];
        n_len    = i_trig[16] ? -$signed(rnd) : $signed(rnd);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len <= n_len;
        end
    end

    assign o_len = r_len;

endmodule

>>> dv/annular_sector_bounding_box_core_test.sv
// ----------------------------------------------------------------------------
// annular_sector_bounding_box_core_test
// drives sector words through the core under random idling on both sides;
// each box word is checked against a fixed box or a sine and case predictor
// ----------------------------------------------------------------------------
module annular_sector_bounding_box_core_test;
    import asbb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RB = 24;
    localparam int AB = 16;
    localparam longint unsigned TURN = 64'd1 << AB;
    localparam longint unsigned QTR = 64'd1 << (AB - 2);
    localparam longint unsigned HALF = 64'd1 << (AB - 1);

    typedef struct packed {
        logic [RB:0] xmin;
        logic [RB:0] ymin;
        logic [RB:0] xmax;
        logic [RB:0] ymax;
    } t_box;

    typedef struct {
        logic [RB-1:0] rin;
        logic [RB-1:0] rout;
        logic [AB-1:0] start;
        logic [AB:0]   span;
        bit            typed;
        t_box          box;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    logic [RB-1:0] i_inner_radius = '0;
    logic [RB-1:0] i_outer_radius = '0;
    logic [AB-1:0] i_start_angle = '0;
    logic [AB:0]   i_span_angle = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    logic signed [RB:0] o_box_xmin, o_box_ymin, o_box_xmax, o_box_ymax;

    t_box boxes_due[$];
    int   errors = 0;
    int   tx_idle = 12;
    int   rx_idle = 76;

    annular_sector_bounding_box_core #(.RADIUS_BITS(RB), .ANGLE_BITS(AB)) uut (.*);

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) i_stall <= ($urandom_range(99) < rx_idle);

    function automatic longint quarter_sine(longint unsigned x);
        longint unsigned z, z2, t, u, s, r;
        z = x << (32 - AB);
        z2 = (z * z) >> 30;
        t = 64'(COEF_A3) - ((64'(COEF_A5) * z2) >> 30);
        u = 64'(COEF_A1) - ((t * z2) >> 30);
        s = (u * z) >> 30;
        r = (s + 64'd16384) >> 15;
        if (r > 32768) r = 32768;
        return longint'(r);
    endfunction

    function automatic void sin_cos(longint unsigned a, output longint sn, output longint cs);
        longint p, c;
        p = quarter_sine(a & (QTR - 1));
        c = quarter_sine(QTR - (a & (QTR - 1)));
        case ((a >> (AB - 2)) & 3)
            0: begin sn = p;  cs = c;  end
            1: begin sn = c;  cs = -p; end
            2: begin sn = -p; cs = -c; end
            default: begin sn = -c; cs = p; end
        endcase
    endfunction

    function automatic longint scaled(longint unsigned r, longint c);
        longint unsigned mag;
        longint p;
        mag = (c < 0) ? longint'(-c) : longint'(c);
        p = longint'((r * mag + 64'd16384) >> 15);
        return (c < 0) ? -p : p;
    endfunction

    function automatic longint lo(longint a, longint b); return a < b ? a : b; endfunction
    function automatic longint hi(longint a, longint b); return a > b ? a : b; endfunction

    function automatic t_box sector_box(longint unsigned rn, longint unsigned rx,
                                        longint unsigned s, longint unsigned d);
        longint r, x0, y0, x1, y1, ss, cs, se, ce;
        longint unsigned e;
        logic [3:0] sec;
        bit back;
        t_box b;
        r = longint'(rx);
        x0 = -r; y0 = -r; x1 = r; y1 = r;
        if (d < TURN) begin
            e = (s + d) & (TURN - 1);
            back = e < s;
            sin_cos(s, ss, cs);
            sin_cos(e, se, ce);
            sec = '0;
            if (e > QTR && e < 3 * QTR) sec[0] = 1'b1;
            if (e > HALF) sec[1] = 1'b1;
            if (s > QTR && s < 3 * QTR) sec[2] = 1'b1;
            if (s > HALF) sec[3] = 1'b1;
            case (sec)
                SEC_PP_PP: if (!back) begin
                    x0 = scaled(rn, ce); y0 = scaled(rn, ss);
                    x1 = scaled(rx, cs); y1 = scaled(rx, se);
                end
                SEC_PP_NP: begin
                    x0 = scaled(rx, ce); y0 = lo(scaled(rn, ss), scaled(rn, se));
                    x1 = scaled(rx, cs);
                end
                SEC_PP_PN: x1 = hi(scaled(rx, cs), scaled(rx, ce));
                SEC_PP_NN: begin y0 = scaled(rx, se); x1 = scaled(rx, cs); end
                SEC_NP_PP: y1 = hi(scaled(rx, ss), scaled(rx, se));
                SEC_NP_NP: if (!back) begin
                    x0 = scaled(rx, ce); y0 = scaled(rn, se);
                    x1 = scaled(rn, cs); y1 = scaled(rx, ss);
                end
                SEC_NP_PN: begin x1 = scaled(rx, ce); y1 = scaled(rx, ss); end
                SEC_NP_NN: begin
                    y0 = scaled(rx, se); x1 = hi(scaled(rn, cs), scaled(rn, ce));
                    y1 = scaled(rx, ss);
                end
                SEC_PN_PP: begin
                    x0 = lo(scaled(rn, cs), scaled(rn, ce));
                    y0 = scaled(rx, ss); y1 = scaled(rx, se);
                end
                SEC_PN_NP: begin x0 = scaled(rx, ce); y0 = scaled(rx, ss); end
                SEC_PN_PN: if (!back) begin
                    x0 = scaled(rn, cs); y0 = scaled(rx, ss);
                    x1 = scaled(rx, ce); y1 = scaled(rn, se);
                end
                SEC_PN_NN: y0 = lo(scaled(rx, ss), scaled(rx, se));
                SEC_NN_PP: begin x0 = scaled(rx, cs); y1 = scaled(rx, se); end
                SEC_NN_NP: x0 = lo(scaled(rx, cs), scaled(rx, ce));
                SEC_NN_PN: begin
                    x0 = scaled(rx, cs); x1 = scaled(rx, ce);
                    y1 = hi(scaled(rn, ss), scaled(rn, se));
                end
                default: if (!back) begin
                    x0 = scaled(rx, cs); y0 = scaled(rx, se);
                    x1 = scaled(rn, ce); y1 = scaled(rn, ss);
                end
            endcase
        end
        b.xmin = x0[RB:0]; b.ymin = y0[RB:0]; b.xmax = x1[RB:0]; b.ymax = y1[RB:0];
        return b;
    endfunction

    function automatic t_box square(longint r);
        t_box b;
        longint n;
        n = -r;
        b.xmin = n[RB:0]; b.ymin = n[RB:0]; b.xmax = r[RB:0]; b.ymax = r[RB:0];
        return b;
    endfunction

    task automatic report_mismatch(string what, logic [RB:0] got, logic [RB:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what,
                 $signed(got), $signed(want), $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_box want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (boxes_due.size() == 0) begin
                $display("unexpected word at %0t", $realtime);
                errors++;
            end else begin
                want = boxes_due.pop_front();
                if (o_box_xmin !== want.xmin) report_mismatch("xmin", o_box_xmin, want.xmin);
                if (o_box_ymin !== want.ymin) report_mismatch("ymin", o_box_ymin, want.ymin);
                if (o_box_xmax !== want.xmax) report_mismatch("xmax", o_box_xmax, want.xmax);
                if (o_box_ymax !== want.ymax) report_mismatch("ymax", o_box_ymax, want.ymax);
            end
        end
    end

    task automatic send_word(t_row w);
        i_inner_radius = w.rin;
        i_outer_radius = w.rout;
        i_start_angle = w.start;
        i_span_angle = w.span;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        boxes_due.push_back(w.typed ? w.box :
                            sector_box(w.rin, w.rout, w.start, w.span));
        @(negedge i_clk);
        if ($urandom_range(99) < tx_idle) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic drain;
        i_valid = 1'b0;
        while (boxes_due.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    function automatic t_row random_word();
        t_row w;
        int k;
        k = $urandom_range(9);
        w.rout = (k < 3) ? RB'($urandom_range(255)) : (k < 8) ? RB'($urandom) :
                 {RB{1'b1}} - RB'($urandom_range(3));
        w.rin = ($urandom_range(9) == 0) ? RB'($urandom) :
                RB'($urandom_range(int'(w.rout)));
        k = $urandom_range(9);
        w.start = (k < 3) ? AB'($urandom_range(3) * QTR + $urandom_range(2)
                                - $urandom_range(2)) : AB'($urandom);
        k = $urandom_range(19);
        if (k == 0) w.span = (AB+1)'(TURN);
        else if (k == 1) w.span = (AB+1)'(TURN + $urandom_range(int'(TURN - 1)));
        else if (k < 5) w.span = (AB+1)'($urandom_range(3) * QTR - w.start % QTR
                                          + $urandom_range(2));
        else if (k < 8) w.span = (AB+1)'($urandom_range(64));
        else w.span = (AB+1)'($urandom_range(int'(TURN - 1)));
        w.typed = 1'b0;
        return w;
    endfunction

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_row table_rows[$];
        t_row w;
        table_rows = '{
            '{24'd0, 24'd0, 16'd0, 17'd0, 1'b1, '0},
            '{24'd0, 24'hFFFFFF, 16'd0, 17'h10000, 1'b1, square(24'hFFFFFF)},
            '{24'd5, 24'd1000, 16'hFFFF, 17'h1FFFF, 1'b1, square(1000)},
            '{24'd5, 24'd1000, 16'd100, 17'hFFFF, 1'b1, square(1000)},
            '{24'd5, 24'd1000, 16'd40000, 17'hFFFF, 1'b1, square(1000)},
            '{24'hFFFFFF, 24'hFFFFFF, 16'd0, 17'd0, 1'b0, '0},
            '{24'hFFFFFF, 24'hFFFFFF, 16'h4000, 17'h4000, 1'b0, '0},
            '{24'd10, 24'd20, 16'h8000, 17'h4000, 1'b0, '0},
            '{24'd10, 24'd20, 16'hC000, 17'h4000, 1'b0, '0},
            '{24'd900, 24'd100, 16'h1000, 17'h2000, 1'b0, '0},
            '{24'd100, 24'hABCDEF, 16'h3FFF, 17'h0002, 1'b0, '0},
            '{24'd100, 24'hABCDEF, 16'h7FFF, 17'h0002, 1'b0, '0},
            '{24'd100, 24'hABCDEF, 16'hBFFF, 17'h0002, 1'b0, '0},
            '{24'd100, 24'hABCDEF, 16'hFFFF, 17'h0002, 1'b0, '0},
            '{24'd3, 24'd77777, 16'h2000, 17'h8000, 1'b0, '0},
            '{24'd3, 24'd77777, 16'h6000, 17'h8000, 1'b0, '0},
            '{24'd3, 24'd77777, 16'hA000, 17'h8000, 1'b0, '0},
            '{24'd3, 24'd77777, 16'hE000, 17'h8000, 1'b0, '0},
            '{24'd3, 24'd77777, 16'h2000, 17'hC000, 1'b0, '0},
            '{24'd3, 24'd77777, 16'h6000, 17'hC000, 1'b0, '0},
            '{24'h555555, 24'hAAAAAA, 16'h5555, 17'h0AAAA, 1'b0, '0},
            '{24'hAAAAAA, 24'h555555, 16'hAAAA, 17'h15555, 1'b0, '0}
        };
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        foreach (table_rows[n]) send_word(table_rows[n]);
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle = (phase == 0) ? 12 : (phase == 1) ? 76 : 0;
            rx_idle = (phase == 0) ? 76 : (phase == 1) ? 12 : 0;
            for (int n = 0; n < 350; n++) begin
                w = random_word();
                send_word(w);
            end
            drain();
        end
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
